// ----- rtl/fvse_pkg.sv -----
// ----------------------------------------------------------------------------
// fvse_pkg
// Shared types, codes and tables of the velocity and sideslip estimator.
// ----------------------------------------------------------------------------
package fvse_pkg;

    localparam int MAX_TAPS_DEF     = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_TAB_LEN   = 24;
    localparam int CORDIC_W         = 36;   // x/y datapath, covers CORDIC gain

    localparam logic [1:0] KIND_POSE = 2'd0;
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_COEF = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;   // unused kind, no effect

    localparam logic [7:0] CFG_TAPS   = 8'd0;
    localparam logic [7:0] CFG_HOFF   = 8'd1;
    localparam logic [7:0] CFG_THR    = 8'd2;
    localparam logic [7:0] CFG_IDEAL  = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PRIME,
        S_FIR_X,
        S_FIR_Y,
        S_DRAIN,
        S_SAT,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_T,
        S_SQ_WAIT,
        S_CMP,
        S_CORD_GO,
        S_CORD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;   // zero both accumulators
        logic go;    // start a multiply
        logic sel;   // 0: accumulate into x, 1: into y
    } t_mac_ctl;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/fvse_mac.sv -----
// ----------------------------------------------------------------------------
// fvse_mac
// Shared 32x32 signed multiplier with registered product and two accumulators.
// ----------------------------------------------------------------------------
module fvse_mac #(
    parameter int MAX_TAPS = fvse_pkg::MAX_TAPS_DEF,
    localparam int AW = 64 + $clog2(MAX_TAPS + 1) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fvse_pkg::t_mac_ctl   i_ctl,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    output logic signed [AW-1:0] o_acc_x,
    output logic signed [AW-1:0] o_acc_y
);

    logic signed [63:0]   r_prod;
    logic                 r_pv;
    logic                 r_psel;
    logic signed [AW-1:0] r_acc_x;
    logic signed [AW-1:0] r_acc_y;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_psel <= i_ctl.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else begin
            r_pv <= i_ctl.go;
            if (i_ctl.clr) begin
                r_acc_x <= '0;
                r_acc_y <= '0;
            end else if (r_pv) begin
                if (r_psel) begin
                    r_acc_y <= r_acc_y + AW'(r_prod);
                end else begin
                    r_acc_x <= r_acc_x + AW'(r_prod);
                end
            end
        end
    end

    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

endmodule

// ----- rtl/fvse_cordic.sv -----
// ----------------------------------------------------------------------------
// fvse_cordic
// Vectoring CORDIC, one micro-rotation per cycle, returns atan2(y, x) in
// 16-bit binary radians.
// ----------------------------------------------------------------------------
module fvse_cordic #(
    parameter int CORDIC_STEPS = fvse_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    output logic               o_done,
    output logic [15:0]        o_angle
);

    localparam int CW    = fvse_pkg::CORDIC_W;
    localparam int STEPS = (CORDIC_STEPS > fvse_pkg::CORDIC_TAB_LEN) ?
                           fvse_pkg::CORDIC_TAB_LEN : CORDIC_STEPS;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [31:0]          r_z;
    logic [4:0]           r_i;
    logic                 r_busy;
    logic                 r_done;
    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [31:0]          z_rnd;

    assign x_ext = CW'(i_x);
    assign y_ext = CW'(i_y);
    assign dx    = r_y >>> r_i;
    assign dy    = r_x >>> r_i;
    assign z_rnd = r_z + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left half plane: rotate by pi first
            if (i_x < 0) begin
                r_x <= -x_ext;
                r_y <= -y_ext;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= x_ext;
                r_y <= y_ext;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + fvse_pkg::atan_lut(r_i);
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - fvse_pkg::atan_lut(r_i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == 5'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = z_rnd[31:16];

endmodule

// ----- rtl/fir_velocity_sideslip_estimator_top.sv -----
// ----------------------------------------------------------------------------
// fir_velocity_sideslip_estimator_top
// Pose-fed FIR velocity estimator with CORDIC sideslip angle.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata pose/coef, tuser kind
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata velocity/angles
//   cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// A pose request in automatic state and outside ideal mode runs the FIR on the
// one shared multiplier (two products per tap), then squares the velocity and
// the threshold for the speed compare, and runs the CORDIC for the angle above
// the threshold before the result is loaded. With zero taps the FIR is skipped.
// Other requests go straight to the load. Synchronous active-low reset clears all history
// and coefficients at once through valid bits. One request at a time; a result
// still held in the output register stalls the next request at its final load.
// ----------------------------------------------------------------------------
module fir_velocity_sideslip_estimator_top #(
    parameter int MAX_TAPS     = fvse_pkg::MAX_TAPS_DEF,
    parameter int CORDIC_STEPS = fvse_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading_in[79:64], automatic_req[80],
    // coef_index[84:81], coef_value[116:85], zero pad
    input  logic [119:0]  s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,   // kind[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // vel_x[31:0], vel_y[63:32], sideslip[79:64], heading_out[95:80],
    // automatic_out[96], zero pad
    output logic [103:0]  m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int AW = 64 + $clog2(MAX_TAPS + 1) + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'(32'h7FFF_FFFF);
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    fvse_pkg::t_state r_state, n_state;

    // configuration
    logic [4:0]  r_taps;
    logic [15:0] r_hoff;
    logic [30:0] r_thr;
    logic        r_ideal;

    // captured request
    logic [1:0]         r_kind;
    logic signed [31:0] r_px, r_py, r_cval;
    logic [15:0]        r_hin;
    logic               r_areq;
    logic [3:0]         r_cidx;

    // state registers
    logic signed [31:0] r_vel_x, r_vel_y;
    logic [15:0]        r_slip, r_head;
    logic               r_auto;

    // history and taps
    logic [31:0]         x_mem [MAX_TAPS];
    logic [31:0]         y_mem [MAX_TAPS];
    logic [31:0]         t_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_hv, r_tv;
    logic [IW-1:0]       r_wp, r_ha, r_k;
    logic [CW-1:0]       r_left;
    logic signed [31:0]  r_xq, r_yq, r_cq;

    logic [IW-1:0] wp_next;
    logic [IW-1:0] ha_dec;
    logic [CW-1:0] n_taps;
    logic          accept;
    logic          coef_ok;

    // control outputs of the sequencer
    logic               rd_en;
    logic               hist_we;
    logic               tap_we;
    logic               sat_we;
    logic               cord_start;
    logic               out_load;
    fvse_pkg::t_mac_ctl mac_ctl;
    logic signed [31:0] mac_a, mac_b;

    logic signed [AW-1:0] acc_x, acc_y, sh_x, sh_y;
    logic                 cord_done;
    logic [15:0]          cord_angle;
    logic                 r_ov;
    logic [103:0]         r_od;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign wp_next     = (r_wp == IW'(MAX_TAPS - 1)) ? '0 : r_wp + IW'(1);
    assign ha_dec      = (r_ha == '0) ? IW'(MAX_TAPS - 1) : r_ha - IW'(1);
    assign n_taps      = (int'(r_taps) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(r_taps);
    assign coef_ok     = int'(r_cidx) < MAX_TAPS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps  <= 5'd8;
            r_hoff  <= '0;
            r_thr   <= '0;
            r_ideal <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fvse_pkg::CFG_TAPS:  r_taps  <= i_cfg_data[4:0];
                fvse_pkg::CFG_HOFF:  r_hoff  <= i_cfg_data[15:0];
                fvse_pkg::CFG_THR:   r_thr   <= i_cfg_data[30:0];
                fvse_pkg::CFG_IDEAL: r_ideal <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_px   <= s_axis_tdata[31:0];
            r_py   <= s_axis_tdata[63:32];
            r_hin  <= s_axis_tdata[79:64];
            r_areq <= s_axis_tdata[80];
            r_cidx <= s_axis_tdata[84:81];
            r_cval <= s_axis_tdata[116:85];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvse_pkg::S_IDLE:   if (accept) n_state = fvse_pkg::S_DECODE;
            fvse_pkg::S_DECODE: begin
                if (r_kind == fvse_pkg::KIND_POSE && !r_ideal && r_auto) begin
                    n_state = (n_taps == '0) ? fvse_pkg::S_SAT : fvse_pkg::S_PRIME;
                end else begin
                    n_state = fvse_pkg::S_DONE;
                end
            end
            fvse_pkg::S_PRIME:  n_state = fvse_pkg::S_FIR_X;
            fvse_pkg::S_FIR_X:  n_state = fvse_pkg::S_FIR_Y;
            fvse_pkg::S_FIR_Y:  n_state = (r_left == CW'(1)) ? fvse_pkg::S_DRAIN
                                                             : fvse_pkg::S_FIR_X;
            fvse_pkg::S_DRAIN:  n_state = fvse_pkg::S_SAT;
            fvse_pkg::S_SAT:    n_state = fvse_pkg::S_SQ_X;
            fvse_pkg::S_SQ_X:   n_state = fvse_pkg::S_SQ_Y;
            fvse_pkg::S_SQ_Y:   n_state = fvse_pkg::S_SQ_T;
            fvse_pkg::S_SQ_T:   n_state = fvse_pkg::S_SQ_WAIT;
            fvse_pkg::S_SQ_WAIT: n_state = fvse_pkg::S_CMP;
            fvse_pkg::S_CMP:    n_state = (acc_x > acc_y) ? fvse_pkg::S_CORD_GO
                                                          : fvse_pkg::S_DONE;
            fvse_pkg::S_CORD_GO: n_state = fvse_pkg::S_CORD_WAIT;
            fvse_pkg::S_CORD_WAIT: if (cord_done) n_state = fvse_pkg::S_DONE;
            fvse_pkg::S_DONE:   if (!r_ov || m_axis_tready) n_state = fvse_pkg::S_IDLE;
            default:            n_state = fvse_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        hist_we       = 1'b0;
        tap_we        = 1'b0;
        sat_we        = 1'b0;
        cord_start    = 1'b0;
        out_load      = 1'b0;
        mac_ctl       = '0;
        mac_a         = r_cq;
        mac_b         = r_xq;
        unique case (r_state)
            fvse_pkg::S_IDLE:   s_axis_tready = 1'b1;
            fvse_pkg::S_DECODE: begin
                hist_we     = (r_kind == fvse_pkg::KIND_POSE) && !r_ideal;
                tap_we      = (r_kind == fvse_pkg::KIND_COEF) && coef_ok;
                mac_ctl.clr = 1'b1;
            end
            fvse_pkg::S_PRIME:  rd_en = 1'b1;
            fvse_pkg::S_FIR_X:  mac_ctl.go = 1'b1;
            fvse_pkg::S_FIR_Y: begin
                mac_ctl.go  = 1'b1;
                mac_ctl.sel = 1'b1;
                mac_b       = r_yq;
                rd_en       = 1'b1;
            end
            fvse_pkg::S_SAT: begin
                sat_we      = 1'b1;
                mac_ctl.clr = 1'b1;
            end
            fvse_pkg::S_SQ_X: begin
                mac_ctl.go = 1'b1;
                mac_a      = r_vel_x;
                mac_b      = r_vel_x;
            end
            fvse_pkg::S_SQ_Y: begin
                mac_ctl.go = 1'b1;
                mac_a      = r_vel_y;
                mac_b      = r_vel_y;
            end
            fvse_pkg::S_SQ_T: begin
                mac_ctl.go  = 1'b1;
                mac_ctl.sel = 1'b1;
                mac_a       = {1'b0, r_thr};
                mac_b       = {1'b0, r_thr};
            end
            fvse_pkg::S_CORD_GO: cord_start = 1'b1;
            fvse_pkg::S_DONE:    out_load   = !r_ov || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fvse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // history and coefficient storage
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            x_mem[wp_next] <= r_px;
            y_mem[wp_next] <= r_py;
        end
        if (tap_we) begin
            t_mem[IW'(r_cidx)] <= r_cval;
        end
        if (rd_en) begin
            r_xq <= r_hv[r_ha] ? x_mem[r_ha] : '0;
            r_yq <= r_hv[r_ha] ? y_mem[r_ha] : '0;
            r_cq <= r_tv[r_k]  ? t_mem[r_k]  : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= '0;
            r_tv   <= '0;
            r_wp   <= '0;
            r_ha   <= '0;
            r_k    <= '0;
            r_left <= '0;
        end else begin
            if (hist_we) begin
                r_hv[wp_next] <= 1'b1;
                r_wp          <= wp_next;
                r_ha          <= wp_next;
                r_k           <= '0;
                r_left        <= n_taps;
            end
            if (tap_we) begin
                r_tv[IW'(r_cidx)] <= 1'b1;
            end
            if (r_state == fvse_pkg::S_FIR_X) begin
                r_ha <= ha_dec;
                r_k  <= r_k + IW'(1);
            end
            if (r_state == fvse_pkg::S_FIR_Y) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    assign sh_x = acc_x >>> 16;
    assign sh_y = acc_y >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_slip  <= '0;
            r_head  <= '0;
            r_auto  <= 1'b0;
        end else begin
            if (r_state == fvse_pkg::S_DECODE) begin
                unique case (r_kind)
                    fvse_pkg::KIND_POSE: begin
                        if (r_ideal) begin
                            r_head <= r_hin;
                        end else begin
                            r_head <= r_hin + r_hoff;
                            if (!r_auto) begin
                                r_vel_x <= '0;
                                r_vel_y <= '0;
                                r_slip  <= '0;
                            end
                        end
                    end
                    fvse_pkg::KIND_MODE: r_auto <= r_areq;
                    default: ;
                endcase
            end
            if (sat_we) begin
                r_vel_x <= (sh_x > SAT_HI) ? 32'sh7FFF_FFFF :
                           (sh_x < SAT_LO) ? 32'sh8000_0000 : sh_x[31:0];
                r_vel_y <= (sh_y > SAT_HI) ? 32'sh7FFF_FFFF :
                           (sh_y < SAT_LO) ? 32'sh8000_0000 : sh_y[31:0];
            end
            if (r_state == fvse_pkg::S_CMP && !(acc_x > acc_y)) begin
                r_slip <= '0;
            end
            if (r_state == fvse_pkg::S_CORD_WAIT && cord_done) begin
                r_slip <= cord_angle - r_head;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_od <= {7'd0, r_auto, r_head, r_slip, r_vel_y, r_vel_x};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    fvse_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc_x (acc_x),
        .o_acc_y (acc_y)
    );

    fvse_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (r_vel_x),
        .i_y     (r_vel_y),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

endmodule

// ----- bench/fir_velocity_sideslip_estimator_top_test.sv -----
// ----------------------------------------------------------------------------
// fir_velocity_sideslip_estimator_top_test
// Drives pose, mode and coefficient requests into the estimator with random
// gaps and output stalls. Each request is predicted in place and every result
// word is checked field by field. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
module fir_velocity_sideslip_estimator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS    = fvse_pkg::MAX_TAPS_DEF;
    localparam int NSTEPS   = fvse_pkg::CORDIC_STEPS_DEF;
    localparam int CYC_MAX  = 2000000;
    localparam logic [7:0] CFG_BAD = 8'd7;   // not a register

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hdg;
        logic        auto_req;
        logic [3:0]  cidx;
        logic [31:0] cval;
    } t_req;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [15:0] slip;
        logic [15:0] hdg;
        logic        auto_st;
    } t_res;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [119:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [103:0]  m_axis_tdata;
    logic          i_cfg_valid = 0;
    logic          o_cfg_ready;
    logic [7:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    fir_velocity_sideslip_estimator_top u_top (.*);

    // predictor state
    logic signed [31:0] x_hist [NTAPS];
    logic signed [31:0] y_hist [NTAPS];
    logic signed [31:0] coefs [NTAPS];
    logic               auto_st;
    logic signed [31:0] vx_st, vy_st;
    logic [15:0]        slip_st, hdg_st;
    logic [4:0]         taps_cfg;
    logic [15:0]        hoff_cfg;
    logic [30:0]        thr_cfg;
    logic               ideal_cfg;

    t_req req_q [$];
    t_res expected_res [$];
    int   errors = 0;
    int   n_sent = 0, n_got = 0, n_pose_auto = 0;
    int   cycles = 0;
    bit   stim_done = 0;

    function automatic void queue_req(input t_req r);
        req_q.insert(req_q.size(), r);
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_MAX) begin
            $display("timeout at %0t", $time);
            $display("fir_velocity_sideslip_estimator_top_test NOT OK");
            $finish;
        end
    end

    function automatic logic signed [31:0] fir_sum(input logic signed [31:0] h [NTAPS]);
        logic signed [80:0] acc;
        int n;
        acc = 0;
        n = (taps_cfg > NTAPS) ? NTAPS : taps_cfg;
        for (int k = 0; k < n; k++) acc += 81'(coefs[k]) * 81'(h[k]);
        acc = acc >>> 16;
        if (acc > 81'sd2147483647) return 32'sh7fffffff;
        if (acc < -81'sd2147483648) return 32'sh80000000;
        return acc[31:0];
    endfunction

    function automatic logic [15:0] angle_of(input logic signed [31:0] vx,
                                             input logic signed [31:0] vy);
        logic signed [47:0] x, y, dx, dy;
        logic [31:0] z;
        x = vx; y = vy; z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += fvse_pkg::atan_lut(5'(i));
            end else begin
                x -= dx; y += dy; z -= fvse_pkg::atan_lut(5'(i));
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic t_res predict_estimate(input t_req r);
        t_res o;
        logic [63:0] sq, thr;
        if (r.kind == fvse_pkg::KIND_POSE) begin
            if (ideal_cfg) hdg_st = r.hdg;
            else begin
                for (int k = NTAPS - 1; k > 0; k--) begin
                    x_hist[k] = x_hist[k-1];
                    y_hist[k] = y_hist[k-1];
                end
                x_hist[0] = r.px;
                y_hist[0] = r.py;
                hdg_st = r.hdg + hoff_cfg;
                if (!auto_st) begin
                    vx_st = 0; vy_st = 0; slip_st = 0;
                end else begin
                    n_pose_auto++;
                    vx_st = fir_sum(x_hist);
                    vy_st = fir_sum(y_hist);
                    sq = 64'(vx_st * 64'sd1 * vx_st) + 64'(vy_st * 64'sd1 * vy_st);
                    thr = 64'(thr_cfg) * 64'(thr_cfg);
                    if (sq > thr) slip_st = angle_of(vx_st, vy_st) - hdg_st;
                    else slip_st = 0;
                end
            end
        end else if (r.kind == fvse_pkg::KIND_MODE) begin
            auto_st = r.auto_req;
        end else if (r.kind == fvse_pkg::KIND_COEF) begin
            coefs[r.cidx] = r.cval;
        end
        o.vx = vx_st; o.vy = vy_st; o.slip = slip_st; o.hdg = hdg_st;
        o.auto_st = auto_st;
        return o;
    endfunction

    // sampled at posedge: did the current request get taken
    bit accepted_last = 1;

    // driver: bursts of requests with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) s_axis_tvalid <= 0;
        else if (!(s_axis_tvalid && !accepted_last)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 0;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                s_axis_tdata <= {3'b0, r.cval, r.cidx, r.auto_req, r.hdg, r.py, r.px};
                s_axis_tuser <= r.kind;
                s_axis_tvalid <= 1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else s_axis_tvalid <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_req r;
        if (s_axis_tvalid && s_axis_tready) begin
            r.kind = s_axis_tuser;
            {r.cval, r.cidx, r.auto_req, r.hdg, r.py, r.px} = s_axis_tdata[116:0];
            expected_res.insert(expected_res.size(), predict_estimate(r));
            n_sent++;
            accepted_last <= 1;
        end else if (s_axis_tvalid) accepted_last <= 0;
        else accepted_last <= 1;
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) m_axis_tready <= 0;
        else if ((stall_phase / 400) % 3 == 0) m_axis_tready <= 1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0) ^ (stall_phase % 7 == 0);
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            {got.auto_st, got.hdg, got.slip, got.vy, got.vx} = m_axis_tdata[96:0];
            n_got++;
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_res.pop_front();
                if (got.vx !== exp_r.vx || got.vy !== exp_r.vy ||
                    got.slip !== exp_r.slip || got.hdg !== exp_r.hdg ||
                    got.auto_st !== exp_r.auto_st) begin
                    $display("%0t: mismatch exp vx=%h vy=%h slip=%h hdg=%h auto=%b",
                             $time, exp_r.vx, exp_r.vy, exp_r.slip, exp_r.hdg,
                             exp_r.auto_st);
                    $display("%0t:          got vx=%h vy=%h slip=%h hdg=%h auto=%b",
                             $time, got.vx, got.vy, got.slip, got.hdg, got.auto_st);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            fvse_pkg::CFG_TAPS:  taps_cfg = val[4:0];
            fvse_pkg::CFG_HOFF:  hoff_cfg = val[15:0];
            fvse_pkg::CFG_THR:   thr_cfg = val[30:0];
            fvse_pkg::CFG_IDEAL: ideal_cfg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (req_q.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_req pose_req(input logic [31:0] x, input logic [31:0] y,
                                      input logic [15:0] h);
        t_req r;
        r = '0;
        r.kind = fvse_pkg::KIND_POSE; r.px = x; r.py = y; r.hdg = h;
        r.cval = $urandom; r.cidx = 4'($urandom); r.auto_req = 1'($urandom);
        return r;
    endfunction

    function automatic t_req mode_req(input logic a);
        t_req r;
        r = pose_req($urandom, $urandom, 16'($urandom));
        r.kind = fvse_pkg::KIND_MODE; r.auto_req = a;
        return r;
    endfunction

    function automatic t_req coef_req(input logic [3:0] i, input logic [31:0] v);
        t_req r;
        r = pose_req($urandom, $urandom, 16'($urandom));
        r.kind = fvse_pkg::KIND_COEF; r.cidx = i; r.cval = v;
        return r;
    endfunction

    // mostly smooth tracks so velocity stays in range, plus full-range noise
    logic signed [31:0] trk_x = 0, trk_y = 0, trk_dx = 0, trk_dy = 0;
    function automatic t_req rand_req();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return mode_req($urandom_range(0, 5) != 0);
        if (sel < 9) return coef_req(4'($urandom), $urandom_range(0, 1) ?
                                     32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) :
                                     $urandom);
        if (sel < 15) return pose_req($urandom, $urandom, 16'($urandom));
        if (sel < 20) {trk_dx, trk_dy} = {32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                                          32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))};
        trk_x = trk_x + trk_dx;
        trk_y = trk_y + trk_dy;
        return pose_req(trk_x, trk_y, 16'($urandom));
    endfunction

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) queue_req(rand_req());
        wait_idle();
    endtask

    initial begin
        for (int k = 0; k < NTAPS; k++) begin
            x_hist[k] = 0; y_hist[k] = 0; coefs[k] = 0;
        end
        auto_st = 0; vx_st = 0; vy_st = 0; slip_st = 0; hdg_st = 0;
        taps_cfg = 8; hoff_cfg = 0; thr_cfg = 0; ideal_cfg = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: safe-state pose, extremes, coefficients, automatic, kind 3
        queue_req(pose_req(32'h7fffffff, 32'h80000000, 16'h7fff));
        queue_req(pose_req(32'h80000000, 32'h7fffffff, 16'h8000));
        queue_req(coef_req(0, 32'h7fffffff));
        queue_req(coef_req(1, 32'h80000000));
        queue_req(coef_req(15, 32'hffffffff));
        queue_req(mode_req(1));
        queue_req(pose_req(32'h7fffffff, 32'h80000000, 16'h0000));
        queue_req(pose_req(32'hffffffff, 32'h00000000, 16'hffff));
        queue_req(coef_req(0, 32'h00010000));
        queue_req(coef_req(1, 32'hffff0000));
        queue_req(coef_req(15, 32'h0));
        queue_req(pose_req(32'h00000000, 32'h00000000, 16'h1234));
        queue_req(pose_req(32'hfff00000, 32'h00100000, 16'h4000));
        queue_req(pose_req(32'h00000000, 32'h00000000, 16'h0));
        begin
            t_req r;
            r = pose_req($urandom, $urandom, 16'($urandom));
            r.kind = fvse_pkg::KIND_NONE;
            queue_req(r);
        end
        queue_req(mode_req(0));
        queue_req(mode_req(1));
        wait_idle();

        write_reg(CFG_BAD, 32'hffffffff);  // unknown index, ignored
        write_reg(fvse_pkg::CFG_TAPS, 32'hffffffe0);
        write_reg(fvse_pkg::CFG_THR, 32'h80000000);
        run_phase(30);
        write_reg(fvse_pkg::CFG_TAPS, 16);
        write_reg(fvse_pkg::CFG_HOFF, 32'h00008000);
        run_phase(250);
        write_reg(fvse_pkg::CFG_TAPS, 31);
        write_reg(fvse_pkg::CFG_HOFF, 32'h00007fff);
        write_reg(fvse_pkg::CFG_THR, 32'h7fffffff);
        run_phase(150);
        write_reg(fvse_pkg::CFG_THR, 32'h00030000);
        write_reg(fvse_pkg::CFG_TAPS, 1);
        run_phase(200);
        write_reg(fvse_pkg::CFG_IDEAL, 1);
        run_phase(100);
        write_reg(fvse_pkg::CFG_IDEAL, 0);
        write_reg(fvse_pkg::CFG_TAPS, 4);
        write_reg(fvse_pkg::CFG_HOFF, $urandom);
        run_phase(350);
        write_reg(fvse_pkg::CFG_TAPS, 8);
        write_reg(fvse_pkg::CFG_THR, 0);
        run_phase(300);

        $display("sent %0d requests, %0d results, %0d filtered poses",
                 n_sent, n_got, n_pose_auto);
        if (errors == 0) $display("fir_velocity_sideslip_estimator_top_test OK");
        else $display("fir_velocity_sideslip_estimator_top_test NOT OK");
        $finish;
    end

endmodule
